@@ rtl/ssui_pkg.sv @@
// ssui_pkg: shared types and constants for the sorted set union/intersect block.
// No dependencies; used by the interfaces, the store, the top level and the checker.
`timescale 1ns / 1ps

package ssui_pkg;

    localparam int unsigned DATA_W = 32;

    typedef enum logic [1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_RUN    = 2'd2,
        OP_CLEAR  = 2'd3
    } t_opcode;

    localparam logic MODE_UNION = 1'b0;
    localparam logic MODE_ISECT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_READ  = 2'd1,
        ST_CMP   = 2'd2,
        ST_FLUSH = 2'd3
    } t_state;

    typedef logic signed [DATA_W-1:0] t_word;

    // control from the sequencer to one store
    typedef struct packed {
        logic clear;
        logic wr_en;
    } t_store_ctl;

endpackage

@@ rtl/ssui_if.sv @@
// ssui_if: valid/ready channel interfaces for requests and results.
// Depends on ssui_pkg.
`timescale 1ns / 1ps

interface ssui_req_if;
    logic               valid;
    logic               ready;
    ssui_pkg::t_opcode  opcode;
    ssui_pkg::t_word    item_value;

    modport source (output valid, output opcode, output item_value, input ready);
    modport sink   (input valid, input opcode, input item_value, output ready);
endinterface

interface ssui_res_if;
    logic               valid;
    logic               ready;
    ssui_pkg::t_word    result_value;
    logic               last_flag;
    logic               empty_flag;
    logic               dropped_flag;

    modport source (output valid, output result_value, output last_flag,
                    output empty_flag, output dropped_flag, input ready);
    modport sink   (input valid, input result_value, input last_flag,
                    input empty_flag, input dropped_flag, output ready);
endinterface

@@ rtl/ssui_store.sv @@
// ssui_store: one element store with append port, fill count and registered read.
// Depends on ssui_pkg.
`timescale 1ns / 1ps

module ssui_store #(
    parameter  int unsigned DEPTH = 32,
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int unsigned CW    = $clog2(DEPTH + 1)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ssui_pkg::t_store_ctl             i_ctl,
    input  ssui_pkg::t_word                  i_wr_data,
    input  logic [AW-1:0]                    i_rd_addr,
    output ssui_pkg::t_word                  o_rd_data,
    output logic [CW-1:0]                    o_count,
    output logic                             o_full
);

    ssui_pkg::t_word r_mem [DEPTH];
    ssui_pkg::t_word r_rd_data;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic            w_full;

    assign w_full = (r_count == CW'(DEPTH));

    always_comb begin
        n_count = r_count;
        if (i_ctl.clear) begin
            n_count = '0;
        end else if (i_ctl.wr_en && !w_full) begin
            n_count = r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // entries are never cleared, only the count is; reads are not checked against the count
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en && !i_ctl.clear && !w_full) begin
            r_mem[r_count[AW-1:0]] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
    assign o_count   = r_count;
    assign o_full    = w_full;

endmodule

@@ rtl/sorted_set_union_intersect.sv @@
// sorted_set_union_intersect: two sorted stores merged by a two-pointer walk.
// Depends on ssui_pkg, ssui_if (ssui_req_if, ssui_res_if) and ssui_store.
//
//  channel   dir  handshake          payload
//  i_req     in   valid/ready        opcode, item_value
//  o_res     out  valid/ready        result_value, last_flag, empty_flag, dropped_flag
//  cfg       in   i_cfg_we           i_cfg_wdata (merge mode, 0 union / 1 intersection)
//
// Load and clear requests are handled in the idle state. A run walks in steps of a
// store read, then a compare in the shared compare unit; one more read/compare
// pair finds the walk done, and a flush state then closes the run.
// i_req.ready is low for the whole run. Reset (synchronous) empties both stores,
// clears the overflow mark and sets union mode. A stalled output holds the walk.
`timescale 1ns / 1ps

module sorted_set_union_intersect #(
    parameter int unsigned SET_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ssui_req_if.sink   i_req,
    ssui_res_if.source o_res,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata
);

    localparam int unsigned AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
    localparam int unsigned CW = $clog2(SET_DEPTH + 1);

    ssui_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_ia, n_ia;
    logic [CW-1:0]    r_ib, n_ib;
    logic             r_mode;
    logic             r_ovf, n_ovf;

    // one result held back so the final one can carry last_flag
    ssui_pkg::t_word  r_pend_val, n_pend_val;
    logic             r_pend_valid, n_pend_valid;

    logic             r_out_valid, n_out_valid;
    ssui_pkg::t_word  r_out_val, n_out_val;
    logic             r_out_last, n_out_last;
    logic             r_out_empty, n_out_empty;
    logic             r_out_drop, n_out_drop;

    ssui_pkg::t_store_ctl w_ctl_a, w_ctl_b;
    ssui_pkg::t_word      w_x, w_y;
    logic [CW-1:0]        w_cnt_a, w_cnt_b;
    logic                 w_full_a, w_full_b;

    logic             w_accept;
    logic             w_slot_free;
    logic             w_eq, w_lt;
    logic             w_a_in, w_b_in;
    logic             w_union;
    logic             w_produce;
    ssui_pkg::t_word  w_prod_val;
    logic             w_adv_a, w_adv_b;
    logic             w_done;

    ssui_store #(.DEPTH(SET_DEPTH)) u_store_a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl_a),
        .i_wr_data (i_req.item_value),
        .i_rd_addr (r_ia[AW-1:0]),
        .o_rd_data (w_x),
        .o_count   (w_cnt_a),
        .o_full    (w_full_a)
    );

    ssui_store #(.DEPTH(SET_DEPTH)) u_store_b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl_b),
        .i_wr_data (i_req.item_value),
        .i_rd_addr (r_ib[AW-1:0]),
        .o_rd_data (w_y),
        .o_count   (w_cnt_b),
        .o_full    (w_full_b)
    );

    assign i_req.ready = (r_state == ssui_pkg::ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_slot_free = !r_out_valid || o_res.ready;
    assign w_union     = (r_mode == ssui_pkg::MODE_UNION);

    // shared compare unit
    assign w_eq = (w_x == w_y);
    assign w_lt = (w_x < w_y);

    assign w_a_in = (r_ia < w_cnt_a);
    assign w_b_in = (r_ib < w_cnt_b);

    // one walk step decision
    always_comb begin
        w_produce  = 1'b0;
        w_prod_val = w_x;
        w_adv_a    = 1'b0;
        w_adv_b    = 1'b0;
        w_done     = 1'b0;
        priority if (w_a_in && w_b_in) begin
            if (w_eq) begin
                w_produce = 1'b1;
                w_adv_a   = 1'b1;
                w_adv_b   = 1'b1;
            end else if (w_lt) begin
                w_produce = w_union;
                w_adv_a   = 1'b1;
            end else begin
                w_produce  = w_union;
                w_prod_val = w_y;
                w_adv_b    = 1'b1;
            end
        end else if (w_union && w_a_in) begin
            w_produce = 1'b1;
            w_adv_a   = 1'b1;
        end else if (w_union && w_b_in) begin
            w_produce  = 1'b1;
            w_prod_val = w_y;
            w_adv_b    = 1'b1;
        end else begin
            w_done = 1'b1;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_ia         = r_ia;
        n_ib         = r_ib;
        n_ovf        = r_ovf;
        n_pend_val   = r_pend_val;
        n_pend_valid = r_pend_valid;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_val    = r_out_val;
        n_out_last   = r_out_last;
        n_out_empty  = r_out_empty;
        n_out_drop   = r_out_drop;
        w_ctl_a      = '0;
        w_ctl_b      = '0;

        unique case (r_state)
            ssui_pkg::ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_req.opcode)
                        ssui_pkg::OP_LOAD_A: begin
                            w_ctl_a.wr_en = 1'b1;
                            if (w_full_a) n_ovf = 1'b1;
                        end
                        ssui_pkg::OP_LOAD_B: begin
                            w_ctl_b.wr_en = 1'b1;
                            if (w_full_b) n_ovf = 1'b1;
                        end
                        ssui_pkg::OP_RUN: begin
                            n_ia    = '0;
                            n_ib    = '0;
                            n_state = ssui_pkg::ST_READ;
                        end
                        ssui_pkg::OP_CLEAR: begin
                            w_ctl_a.clear = 1'b1;
                            w_ctl_b.clear = 1'b1;
                            n_ovf         = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ssui_pkg::ST_READ: begin
                n_state = ssui_pkg::ST_CMP;
            end
            ssui_pkg::ST_CMP: begin
                if (w_done) begin
                    n_state = ssui_pkg::ST_FLUSH;
                end else if (!(w_produce && r_pend_valid && !w_slot_free)) begin
                    if (w_produce) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_val   = r_pend_val;
                            n_out_last  = 1'b0;
                            n_out_empty = 1'b0;
                            n_out_drop  = r_ovf;
                        end
                        n_pend_val   = w_prod_val;
                        n_pend_valid = 1'b1;
                    end
                    if (w_adv_a) n_ia = r_ia + CW'(1);
                    if (w_adv_b) n_ib = r_ib + CW'(1);
                    n_state = ssui_pkg::ST_READ;
                end
            end
            ssui_pkg::ST_FLUSH: begin
                if (w_slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_val    = r_pend_valid ? r_pend_val : '0;
                    n_out_last   = 1'b1;
                    n_out_empty  = !r_pend_valid;
                    n_out_drop   = r_ovf;
                    n_pend_valid = 1'b0;
                    n_state      = ssui_pkg::ST_IDLE;
                end
            end
            default: n_state = ssui_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ssui_pkg::ST_IDLE;
            r_ia         <= '0;
            r_ib         <= '0;
            r_mode       <= ssui_pkg::MODE_UNION;
            r_ovf        <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ia         <= n_ia;
            r_ib         <= n_ib;
            r_ovf        <= n_ovf;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) r_mode <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_val  <= n_pend_val;
        r_out_val   <= n_out_val;
        r_out_last  <= n_out_last;
        r_out_empty <= n_out_empty;
        r_out_drop  <= n_out_drop;
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.result_value = r_out_val;
    assign o_res.last_flag    = r_out_last;
    assign o_res.empty_flag   = r_out_empty;
    assign o_res.dropped_flag = r_out_drop;

endmodule

@@ rtl/ssui_chk.sv @@
// ssui_chk: port-level checks for sorted_set_union_intersect, bound to the top level.
// Depends on ssui_pkg and sorted_set_union_intersect.
`timescale 1ns / 1ps

module ssui_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_valid,
    input logic              i_req_ready,
    input ssui_pkg::t_opcode i_req_opcode,
    input logic              i_res_valid,
    input logic              i_res_ready,
    input ssui_pkg::t_word   i_res_value,
    input logic              i_res_last,
    input logic              i_res_empty
);

    // a result waiting on the sink is not withdrawn
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result withdrawn while stalled");

    // the empty answer is a single zero item that closes the run
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_empty |-> i_res_last && (i_res_value == '0))
        else $error("empty result not a lone zero last item");

    // a run request closes the request channel while the walk goes on
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && (i_req_opcode == ssui_pkg::OP_RUN) |=> !i_req_ready)
        else $error("request taken during a run");

    // reset leaves no result pending
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

endmodule

bind sorted_set_union_intersect ssui_chk u_ssui_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_req_opcode (i_req.opcode),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_value  (o_res.result_value),
    .i_res_last   (o_res.last_flag),
    .i_res_empty  (o_res.empty_flag)
);
